/* design/ldc_pkg.sv */
// shared types, widths and helpers for the light dip counter
// no dependencies; used by every module of the block
package ldc_pkg;

  // field widths
  localparam int SAMPLE_BITS = 12;
  localparam int TIME_BITS   = 32;
  localparam int COUNT_BITS  = 16;

  // stream and configuration port widths
  localparam int IN_FIELD_BITS  = SAMPLE_BITS + TIME_BITS;
  localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 1 + 2 * COUNT_BITS + 2 * SAMPLE_BITS + 2 * TIME_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int CFG_DATA_BITS  = TIME_BITS;
  localparam int CFG_INDEX_BITS = 2;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD      = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_OFFSET   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_INTERVAL = 2'd2;

  // register reset values
  localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET      = SAMPLE_BITS'(2048);
  localparam logic [SAMPLE_BITS-1:0] START_OFFSET_RESET   = SAMPLE_BITS'(683);
  localparam logic [TIME_BITS-1:0]   FIRST_INTERVAL_RESET = TIME_BITS'(1000);

  // reciprocal of ten, exact floor for operands below 2^16
  localparam int DIV10_MUL_BITS = 17;
  localparam logic [DIV10_MUL_BITS-1:0] DIV10_MUL = 17'd52429;
  localparam int DIV10_SHIFT = 19;

  typedef logic [SAMPLE_BITS-1:0] level_t;
  typedef logic [TIME_BITS-1:0]   ticks_t;
  typedef logic [COUNT_BITS-1:0]  count_t;

  // configuration seen by the units
  typedef struct packed {
    level_t threshold;
    level_t start_offset;
    ticks_t first_interval;
  } cfg_t;

  // one accepted sample beat, with its load strobe
  typedef struct packed {
    logic   load;
    level_t level;
    ticks_t time_stamp;
    logic   window_start;
  } step_t;

  // dip line: threshold minus floor(threshold / 10)
  function automatic level_t dip_line(input level_t thr);
    logic [SAMPLE_BITS+DIV10_MUL_BITS-1:0] prod;
    level_t tenth;
    prod  = (SAMPLE_BITS + DIV10_MUL_BITS)'(thr)
          * (SAMPLE_BITS + DIV10_MUL_BITS)'(DIV10_MUL);
    tenth = SAMPLE_BITS'(prod >> DIV10_SHIFT);
    return thr - tenth;
  endfunction

  // saturating increment
  function automatic count_t sat_inc(input count_t c);
    return (c == '1) ? c : c + COUNT_BITS'(1);
  endfunction

endpackage

/* design/ldc_dip_unit.sv */
// dip detection and per-window dip and sample counters
// depends on ldc_pkg
module ldc_dip_unit (
  input  logic           clk,
  input  logic           rst,
  input  ldc_pkg::cfg_t  cfg,
  input  ldc_pkg::step_t step,
  output logic           dip_seen,
  output ldc_pkg::count_t dip_counter,
  output ldc_pkg::count_t sample_counter
);

  ldc_pkg::level_t previous_level;
  ldc_pkg::level_t seed;
  ldc_pkg::level_t prev_eff;
  ldc_pkg::level_t line;
  ldc_pkg::count_t dip_base;
  ldc_pkg::count_t sample_base;
  logic            dip;

  // seed at window start, clamped at zero
  always_comb begin
    seed = (cfg.start_offset > cfg.threshold) ? '0 : cfg.threshold - cfg.start_offset;
    prev_eff    = step.window_start ? seed : previous_level;
    line        = ldc_pkg::dip_line(cfg.threshold);
    dip         = (prev_eff > line) && (step.level < line);
    dip_base    = step.window_start ? '0 : dip_counter;
    sample_base = step.window_start ? '0 : sample_counter;
  end

  // state and result update per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level <= '0;
      dip_counter    <= '0;
      sample_counter <= '0;
      dip_seen       <= 1'b0;
    end else if (step.load) begin
      previous_level <= step.level;
      dip_counter    <= dip ? ldc_pkg::sat_inc(dip_base) : dip_base;
      sample_counter <= ldc_pkg::sat_inc(sample_base);
      dip_seen       <= dip;
    end
  end

endmodule

/* design/ldc_extreme_unit.sv */
// all-time level and gap extremes
// depends on ldc_pkg
module ldc_extreme_unit (
  input  logic           clk,
  input  logic           rst,
  input  ldc_pkg::cfg_t  cfg,
  input  ldc_pkg::step_t step,
  output ldc_pkg::level_t max_level,
  output ldc_pkg::level_t min_level,
  output ldc_pkg::ticks_t max_gap,
  output ldc_pkg::ticks_t min_gap
);

  ldc_pkg::ticks_t previous_time;
  ldc_pkg::ticks_t gap;

  // gap wraps modulo the time width
  assign gap = step.window_start ? cfg.first_interval : step.time_stamp - previous_time;

  // running extremes
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_time <= '0;
      max_level     <= '0;
      min_level     <= '1;
      max_gap       <= '0;
      min_gap       <= '1;
    end else if (step.load) begin
      previous_time <= step.time_stamp;
      if (step.level > max_level) max_level <= step.level;
      if (step.level < min_level) min_level <= step.level;
      if (gap > max_gap) max_gap <= gap;
      if (gap < min_gap) min_gap <= gap;
    end
  end

endmodule

/* design/light_dip_counter_with_extremes_top.sv */
// Light dip counter with all-time extremes: one light sample per beat in, one result
// beat out. The unit registers hold the result and are loaded at the edge that
// accepts the sample, so a new sample is taken every cycle while the result side keeps
// up; the path between registers is one reciprocal multiply for the dip line plus
// compares and a 32-bit subtract for the gap.
// Configuration writes are applied at once and must come while no beat is in flight.
// depends on ldc_pkg, ldc_dip_unit, ldc_extreme_unit
module light_dip_counter_with_extremes_top (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [ldc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [ldc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  // sample stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [ldc_pkg::IN_DATA_BITS-1:0]    s_tdata,  // level, time_stamp, zero pad
  input  logic                                s_tuser,  // window_start
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // dip_seen, dip_total, sample_total, highest_level, lowest_level,
  // longest_gap, shortest_gap, zero pad
  output logic [ldc_pkg::OUT_DATA_BITS-1:0]   m_tdata
);

  ldc_pkg::cfg_t   cfg;
  ldc_pkg::step_t  step;
  logic            accept;
  logic            dip_seen;
  ldc_pkg::count_t dip_total;
  ldc_pkg::count_t sample_total;
  ldc_pkg::level_t highest_level;
  ldc_pkg::level_t lowest_level;
  ldc_pkg::ticks_t longest_gap;
  ldc_pkg::ticks_t shortest_gap;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold      <= ldc_pkg::THRESHOLD_RESET;
      cfg.start_offset   <= ldc_pkg::START_OFFSET_RESET;
      cfg.first_interval <= ldc_pkg::FIRST_INTERVAL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ldc_pkg::REG_THRESHOLD:      cfg.threshold      <= cfg_data[ldc_pkg::SAMPLE_BITS-1:0];
        ldc_pkg::REG_START_OFFSET:   cfg.start_offset   <= cfg_data[ldc_pkg::SAMPLE_BITS-1:0];
        ldc_pkg::REG_FIRST_INTERVAL: cfg.first_interval <= cfg_data[ldc_pkg::TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  // handshake: result registers reload when empty or being drained
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  // unpack the incoming beat
  always_comb begin
    step.load         = accept;
    step.level        = s_tdata[ldc_pkg::SAMPLE_BITS-1:0];
    step.time_stamp   = s_tdata[ldc_pkg::IN_FIELD_BITS-1:ldc_pkg::SAMPLE_BITS];
    step.window_start = s_tuser;
  end

  ldc_dip_unit u_dip (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .step           (step),
    .dip_seen       (dip_seen),
    .dip_counter    (dip_total),
    .sample_counter (sample_total)
  );

  ldc_extreme_unit u_extreme (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (step),
    .max_level (highest_level),
    .min_level (lowest_level),
    .max_gap   (longest_gap),
    .min_gap   (shortest_gap)
  );

  // pack the result beat
  assign m_tdata = ldc_pkg::OUT_DATA_BITS'({shortest_gap, longest_gap, lowest_level,
                                            highest_level, sample_total, dip_total,
                                            dip_seen});

  // a window-start beat restarts the sample count at one
  a_window_restart : assert property (@(posedge clk) disable iff (rst)
    accept && s_tuser |=> sample_total == ldc_pkg::COUNT_BITS'(1))
    else $error("sample count not restarted on window start");

  // a reported dip is always reflected in the dip count
  a_dip_counted : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && dip_seen |-> dip_total != '0)
    else $error("dip reported with zero dip count");

  // once a sample has been seen the level extremes are ordered
  a_extremes_ordered : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> lowest_level <= highest_level)
    else $error("lowest level above highest level");

  // at most as many dips as samples in a window
  a_dips_bounded : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> dip_total <= sample_total)
    else $error("dip count exceeds sample count");

endmodule
